// ----- rtl/rigid_body_mass_accumulator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Rigid body mass accumulator: assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_MASS_ACCUMULATOR_TOP_DEFINES_SVH
`define RIGID_BODY_MASS_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RBMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbma assertion failed");

// Next-cycle implication, checked out of reset.
`define RBMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbma assertion failed");

`endif

// ----- rtl/rbma_pkg.sv -----
// ----------------------------------------------------------------------------
// Rigid body mass accumulator package
// Request and result types, operation codes and term tables.
// ----------------------------------------------------------------------------
package rbma_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DIV_STEPS     = 33;
  localparam int unsigned N_TERMS       = 12;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_SCALE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        part_mass;
    logic signed [31:0] part_com_x;
    logic signed [31:0] part_com_y;
    logic signed [31:0] part_com_z;
    logic signed [47:0] part_ixx;
    logic signed [47:0] part_iyy;
    logic signed [47:0] part_izz;
    logic signed [47:0] part_ixy;
    logic signed [47:0] part_ixz;
    logic signed [47:0] part_iyz;
    logic [31:0]        scale_coeff;
  } in_t;

  typedef struct packed {
    logic [31:0]        total_mass;
    logic signed [31:0] com_x;
    logic signed [31:0] com_y;
    logic signed [31:0] com_z;
    logic signed [47:0] ixx;
    logic signed [47:0] iyy;
    logic signed [47:0] izz;
    logic signed [47:0] ixy;
    logic signed [47:0] ixz;
    logic signed [47:0] iyz;
    logic               zero_mass_flag;
  } out_t;

  // Shift-vector products: xx, yy, zz, xy, xz, yz.
  function automatic logic [1:0] pair_u(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd0;
      3'd5:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_v(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd1;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/rigid_body_mass_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// Rigid body mass accumulator
// Running mass, centre of mass and inertia tensor with add, scale and clear.
// ----------------------------------------------------------------------------
// One request is worked on at a time, and in_ready is high only while the
// sequencer is idle. All arithmetic runs through a single registered 32x32
// multiplier and a one-bit-per-cycle restoring divider. An add runs, per
// axis, a product, a divider load, 33 divide steps and a centre update,
// then 12 parallel-axis terms through states S_T0 to S_T4 each, then
// commit and result load. A scale runs 7 products through S_T1 to S_T4
// each; a clear or an unused code goes straight to commit and result load.
// The result register frees the input side: a new request is taken while
// the previous result still waits for out_ready.
module rigid_body_mass_accumulator_top #(
  parameter int unsigned FRAC_BITS = rbma_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rbma_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rbma_pkg::out_t out_data
);

  localparam int unsigned SH_ADD   = 2 * FRAC_BITS;
  localparam int unsigned SH_SCALE = FRAC_BITS;
  localparam logic [95:0] TERM_CLAMP = 96'd1 << 60;
  localparam logic [63:0] I48_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] I48_MIN = 64'hFFFF_8000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_DLOAD, S_DIV, S_DFIN,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_FIN, S_DONE
  } state_t;

  state_t state_r;

  // Accumulator state.
  logic [31:0] mass_r;
  logic [31:0] com_r [3];
  logic [47:0] inertia_r [6];

  // Working registers.
  logic [1:0]  func_r;
  logic [31:0] pm_r;
  logic [31:0] pc_r [3];
  logic [31:0] coeff_r;
  logic [32:0] tsum_r;
  logic [63:0] sum_r [6];
  logic [31:0] nc_r [3];
  logic [31:0] al_mag_r [3];
  logic        al_neg_r [3];
  logic [31:0] ar_mag_r [3];
  logic        ar_neg_r [3];
  logic [1:0]  axis_r;
  logic        d_neg_r;
  logic [32:0] rem_r;
  logic [32:0] quo_r;
  logic [5:0]  div_cnt_r;
  logic [63:0] prod_r;
  logic [31:0] mag_hi_r;
  logic [95:0] acc_r;
  logic [3:0]  term_r;
  logic        term_neg_r;

  logic           out_valid_r;
  rbma_pkg::out_t out_data_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  function automatic logic [47:0] sat48(input logic [63:0] v);
    logic [47:0] r;
    if ($signed(v) > $signed(I48_MAX)) begin
      r = I48_MAX[47:0];
    end else if ($signed(v) < $signed(I48_MIN)) begin
      r = I48_MIN[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // Part tensor in state order.
  logic [47:0] pin [6];
  assign pin[0] = in_data.part_ixx;
  assign pin[1] = in_data.part_iyy;
  assign pin[2] = in_data.part_izz;
  assign pin[3] = in_data.part_ixy;
  assign pin[4] = in_data.part_ixz;
  assign pin[5] = in_data.part_iyz;

  // Centre difference for the current axis.
  logic [32:0] d_full, d_negv;
  logic [31:0] d_mag;
  assign d_full = {pc_r[axis_r][31], pc_r[axis_r]} - {com_r[axis_r][31], com_r[axis_r]};
  assign d_negv = -d_full;
  assign d_mag  = d_full[32] ? d_negv[31:0] : d_full[31:0];

  // Restoring divider step.
  logic [33:0] div_trial, div_diff;
  logic        div_ge;
  assign div_trial = {rem_r, quo_r[32]};
  assign div_diff  = div_trial - {1'b0, tsum_r};
  assign div_ge    = (div_trial >= {1'b0, tsum_r});

  // New centre and shift vectors for the current axis.
  logic [33:0] q_ext, q_sgn, nc_full;
  logic [31:0] nc_v;
  logic [32:0] ar_full, ar_negv;
  assign q_ext   = {2'b00, quo_r[31:0]};
  assign q_sgn   = d_neg_r ? (~q_ext + 34'd1) : q_ext;
  assign nc_full = {{2{com_r[axis_r][31]}}, com_r[axis_r]} + q_sgn;
  assign nc_v    = nc_full[31:0];
  assign ar_full = {nc_v[31], nc_v} - {pc_r[axis_r][31], pc_r[axis_r]};
  assign ar_negv = -ar_full;

  // Term selection.
  logic [2:0]  pair;
  logic [1:0]  uidx, vidx;
  logic        use_l;
  logic [31:0] u_mag, v_mag, mass_sel;
  logic        u_neg, v_neg;
  logic [2:0]  ent_idx;
  logic [47:0] ent_v, ent_negv, ent_mag;
  logic [31:0] t1_lo, t1_hi;
  logic        t1_neg;
  assign use_l = (term_r < 4'd6);
  assign pair  = use_l ? term_r[2:0] : 3'(term_r - 4'd6);
  assign uidx  = rbma_pkg::pair_u(pair);
  assign vidx  = rbma_pkg::pair_v(pair);
  assign u_mag = use_l ? al_mag_r[uidx] : ar_mag_r[uidx];
  assign v_mag = use_l ? al_mag_r[vidx] : ar_mag_r[vidx];
  assign u_neg = use_l ? al_neg_r[uidx] : ar_neg_r[uidx];
  assign v_neg = use_l ? al_neg_r[vidx] : ar_neg_r[vidx];
  assign mass_sel = (func_r == rbma_pkg::FUNC_ADD) ? (use_l ? mass_r : pm_r) : coeff_r;

  assign ent_idx  = (term_r == 4'd0) ? 3'd0 : 3'(term_r - 4'd1);
  assign ent_v    = inertia_r[ent_idx];
  assign ent_negv = -ent_v;
  assign ent_mag  = ent_v[47] ? ent_negv : ent_v;

  always_comb begin
    if (func_r == rbma_pkg::FUNC_ADD) begin
      t1_lo  = prod_r[31:0];
      t1_hi  = prod_r[63:32];
      t1_neg = u_neg ^ v_neg;
    end else if (term_r == 4'd0) begin
      t1_lo  = mass_r;
      t1_hi  = 32'd0;
      t1_neg = 1'b0;
    end else begin
      t1_lo  = ent_mag[31:0];
      t1_hi  = {16'd0, ent_mag[47:32]};
      t1_neg = ent_v[47];
    end
  end

  // Shared multiplier operands.
  logic [31:0] mul_a, mul_b;
  always_comb begin
    unique case (state_r)
      S_DIFF: begin
        mul_a = d_mag;
        mul_b = pm_r;
      end
      S_T0: begin
        mul_a = u_mag;
        mul_b = v_mag;
      end
      S_T1: begin
        mul_a = mass_sel;
        mul_b = t1_lo;
      end
      S_T2: begin
        mul_a = mass_sel;
        mul_b = mag_hi_r;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Shift, clamp and sign of a finished product.
  logic [95:0] sh_v;
  logic [60:0] tmag;
  logic [63:0] tpos, tval;
  assign sh_v = (func_r == rbma_pkg::FUNC_ADD) ? (acc_r >> SH_ADD) : (acc_r >> SH_SCALE);
  assign tmag = (sh_v > TERM_CLAMP) ? TERM_CLAMP[60:0] : sh_v[60:0];
  assign tpos = {3'd0, tmag};
  assign tval = term_neg_r ? -tpos : tpos;

  logic [3:0] last_term;
  assign last_term = (func_r == rbma_pkg::FUNC_ADD) ? 4'(rbma_pkg::N_TERMS - 1) : 4'd6;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mass_r      <= 32'd0;
      for (int i = 0; i < 3; i++) com_r[i] <= 32'd0;
      for (int i = 0; i < 6; i++) inertia_r[i] <= 48'd0;
    end else begin
      // In S_DONE the result register is reloaded instead.
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r   <= in_data.func;
            pm_r     <= in_data.part_mass;
            pc_r[0]  <= in_data.part_com_x;
            pc_r[1]  <= in_data.part_com_y;
            pc_r[2]  <= in_data.part_com_z;
            coeff_r  <= in_data.scale_coeff;
            tsum_r   <= {1'b0, mass_r} + {1'b0, in_data.part_mass};
            for (int i = 0; i < 6; i++) begin
              sum_r[i] <= {{16{inertia_r[i][47]}}, inertia_r[i]} + {{16{pin[i][47]}}, pin[i]};
            end
            axis_r <= 2'd0;
            term_r <= 4'd0;
            unique case (in_data.func)
              rbma_pkg::FUNC_ADD:   state_r <= S_DIFF;
              rbma_pkg::FUNC_SCALE: state_r <= S_T1;
              default:              state_r <= S_FIN;
            endcase
          end
        end
        S_DIFF: begin
          d_neg_r <= d_full[32];
          state_r <= S_DLOAD;
        end
        S_DLOAD: begin
          div_cnt_r <= 6'd0;
          if (tsum_r == 33'd0) begin
            quo_r   <= 33'd0;
            state_r <= S_DFIN;
          end else begin
            // The quotient is below 2^33, so the top dividend bits are below the divisor.
            rem_r   <= {2'b00, prod_r[63:33]};
            quo_r   <= prod_r[32:0];
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r     <= div_ge ? div_diff[32:0] : div_trial[32:0];
          quo_r     <= {quo_r[31:0], div_ge};
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'(rbma_pkg::DIV_STEPS - 1)) begin
            state_r <= S_DFIN;
          end
        end
        S_DFIN: begin
          nc_r[axis_r]     <= nc_v;
          al_mag_r[axis_r] <= quo_r[31:0];
          al_neg_r[axis_r] <= d_neg_r;
          ar_mag_r[axis_r] <= ar_full[32] ? ar_negv[31:0] : ar_full[31:0];
          ar_neg_r[axis_r] <= ar_full[32];
          if (axis_r == 2'd2) begin
            state_r <= S_T0;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_DIFF;
          end
        end
        S_T0: begin
          state_r <= S_T1;
        end
        S_T1: begin
          mag_hi_r   <= t1_hi;
          term_neg_r <= t1_neg;
          state_r    <= S_T2;
        end
        S_T2: begin
          acc_r   <= {32'd0, prod_r};
          state_r <= S_T3;
        end
        S_T3: begin
          acc_r   <= acc_r + {prod_r, 32'd0};
          state_r <= S_T4;
        end
        S_T4: begin
          if (func_r == rbma_pkg::FUNC_ADD) begin
            case (pair)
              3'd0: begin
                sum_r[1] <= sum_r[1] + tval;
                sum_r[2] <= sum_r[2] + tval;
              end
              3'd1: begin
                sum_r[0] <= sum_r[0] + tval;
                sum_r[2] <= sum_r[2] + tval;
              end
              3'd2: begin
                sum_r[0] <= sum_r[0] + tval;
                sum_r[1] <= sum_r[1] + tval;
              end
              3'd3:    sum_r[3] <= sum_r[3] - tval;
              3'd4:    sum_r[4] <= sum_r[4] - tval;
              default: sum_r[5] <= sum_r[5] - tval;
            endcase
          end else if (term_r == 4'd0) begin
            tsum_r <= (tmag > 61'h0_FFFF_FFFF) ? {1'b0, 32'hFFFF_FFFF} : {1'b0, tmag[31:0]};
          end else begin
            sum_r[ent_idx] <= tval;
          end
          if (term_r == last_term) begin
            state_r <= S_FIN;
          end else begin
            term_r  <= term_r + 4'd1;
            state_r <= (func_r == rbma_pkg::FUNC_ADD) ? S_T0 : S_T1;
          end
        end
        S_FIN: begin
          case (func_r) inside
            rbma_pkg::FUNC_ADD, rbma_pkg::FUNC_SCALE: begin
              mass_r <= tsum_r[32] ? 32'hFFFF_FFFF : tsum_r[31:0];
              for (int i = 0; i < 6; i++) inertia_r[i] <= sat48(sum_r[i]);
              if (func_r == rbma_pkg::FUNC_ADD) begin
                for (int i = 0; i < 3; i++) com_r[i] <= nc_r[i];
              end
            end
            rbma_pkg::FUNC_CLEAR: begin
              mass_r <= 32'd0;
              for (int i = 0; i < 3; i++) com_r[i] <= 32'd0;
              for (int i = 0; i < 6; i++) inertia_r[i] <= 48'd0;
            end
            default: begin
            end
          endcase
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.total_mass     <= mass_r;
            out_data_r.com_x          <= com_r[0];
            out_data_r.com_y          <= com_r[1];
            out_data_r.com_z          <= com_r[2];
            out_data_r.ixx            <= inertia_r[0];
            out_data_r.iyy            <= inertia_r[1];
            out_data_r.izz            <= inertia_r[2];
            out_data_r.ixy            <= inertia_r[3];
            out_data_r.ixz            <= inertia_r[4];
            out_data_r.iyz            <= inertia_r[5];
            out_data_r.zero_mass_flag <= (mass_r == 32'd0);
            out_valid_r               <= 1'b1;
            state_r                   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "rigid_body_mass_accumulator_top_defines.svh"

  `RBMA_ASSERT_NOW(a_div_rem_below, clk, rst_n, state_r == S_DIV, rem_r < tsum_r)
  `RBMA_ASSERT_NEXT(a_clear_zeroes, clk, rst_n,
    state_r == S_FIN && func_r == rbma_pkg::FUNC_CLEAR, mass_r == 32'd0)
  `RBMA_ASSERT_NOW(a_flag_matches, clk, rst_n, out_valid_r,
    out_data_r.zero_mass_flag == (out_data_r.total_mass == 32'd0))

endmodule

// ----- bench/tb_rigid_body_mass_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// Rigid body mass accumulator testbench
// Drives add, scale, clear and unused requests with random gaps on both
// channels and checks every result against a built-in model or a typed value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rigid_body_mass_accumulator_top;

  localparam int unsigned FB          = 16;
  localparam int          N_RANDOM    = 1500;
  localparam longint      CYCLE_LIMIT = 3000000;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic signed [63:0] I48_HI = 64'sd140737488355327;
  localparam logic signed [63:0] I48_LO = -64'sd140737488355328;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rbma_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  rbma_pkg::out_t out_data;

  rigid_body_mass_accumulator_top #(.FRAC_BITS(FB)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Body state as the model sees it.
  logic [31:0]        body_mass;
  logic signed [31:0] body_com [3];
  logic signed [47:0] body_inertia [6];

  rbma_pkg::out_t result_q [$];
  bit             typed_has_q [$];
  rbma_pkg::out_t typed_val_q [$];
  int     fail_count;
  int     results_seen;
  longint cycle_count;

  function automatic logic [63:0] mag64(logic signed [63:0] u);
    return (u < 0) ? -u : u;
  endfunction

  function automatic logic [63:0] mul_shift_clamp(logic [31:0] m, logic [63:0] mg, int s);
    logic [127:0] p;
    p = {96'b0, m} * {64'b0, mg};
    p = p >> s;
    if (p > (128'd1 << 60)) return 64'd1 << 60;
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] axis_term(logic [31:0] m,
                                                   logic signed [63:0] u,
                                                   logic signed [63:0] v);
    logic [63:0] t;
    t = mul_shift_clamp(m, mag64(u) * mag64(v), 2 * FB);
    return ((u < 0) != (v < 0)) ? -$signed(t) : $signed(t);
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [63:0] v);
    if (v > I48_HI) return I48_HI[47:0];
    if (v < I48_LO) return I48_LO[47:0];
    return v[47:0];
  endfunction

  function automatic void parallel_axis(inout logic signed [63:0] s [6],
                                        input logic [31:0] m,
                                        input logic signed [63:0] a [3]);
    s[0] += axis_term(m, a[1], a[1]) + axis_term(m, a[2], a[2]);
    s[1] += axis_term(m, a[0], a[0]) + axis_term(m, a[2], a[2]);
    s[2] += axis_term(m, a[0], a[0]) + axis_term(m, a[1], a[1]);
    s[3] -= axis_term(m, a[0], a[1]);
    s[4] -= axis_term(m, a[0], a[2]);
    s[5] -= axis_term(m, a[1], a[2]);
  endfunction

  // Applies one request to the body state and returns the state after it.
  function automatic rbma_pkg::out_t predict_body(rbma_pkg::in_t r);
    rbma_pkg::out_t     o;
    logic [32:0]        total;
    logic signed [63:0] pc [3];
    logic signed [63:0] nc [3];
    logic signed [63:0] al [3];
    logic signed [63:0] ar [3];
    logic signed [63:0] s [6];
    logic signed [63:0] part_i [6];
    logic signed [63:0] d;
    logic [127:0]       num;
    logic [63:0]        q;
    logic [63:0]        sm;
    logic [63:0]        t;
    if (r.func == rbma_pkg::FUNC_ADD) begin
      total = {1'b0, body_mass} + {1'b0, r.part_mass};
      pc[0] = 64'(r.part_com_x);
      pc[1] = 64'(r.part_com_y);
      pc[2] = 64'(r.part_com_z);
      part_i[0] = 64'(r.part_ixx);
      part_i[1] = 64'(r.part_iyy);
      part_i[2] = 64'(r.part_izz);
      part_i[3] = 64'(r.part_ixy);
      part_i[4] = 64'(r.part_ixz);
      part_i[5] = 64'(r.part_iyz);
      for (int i = 0; i < 3; i++) begin
        nc[i] = 64'(body_com[i]);
        if (total != 0) begin
          d = pc[i] - nc[i];
          num = {64'b0, mag64(d)} * {96'b0, r.part_mass};
          q = 64'(num / {95'b0, total});
          nc[i] = (d < 0) ? nc[i] - $signed(q) : nc[i] + $signed(q);
        end
        al[i] = nc[i] - 64'(body_com[i]);
        ar[i] = nc[i] - pc[i];
      end
      for (int i = 0; i < 6; i++) s[i] = 64'(body_inertia[i]) + part_i[i];
      parallel_axis(s, body_mass, al);
      parallel_axis(s, r.part_mass, ar);
      for (int i = 0; i < 6; i++) body_inertia[i] = sat48(s[i]);
      for (int i = 0; i < 3; i++) body_com[i] = nc[i][31:0];
      body_mass = total[32] ? 32'hFFFF_FFFF : total[31:0];
    end else if (r.func == rbma_pkg::FUNC_SCALE) begin
      sm = ({32'b0, body_mass} * {32'b0, r.scale_coeff}) >> FB;
      body_mass = (sm > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sm[31:0];
      for (int i = 0; i < 6; i++) begin
        t = mul_shift_clamp(r.scale_coeff, mag64(64'(body_inertia[i])), FB);
        body_inertia[i] = sat48((body_inertia[i] < 0) ? -$signed(t) : $signed(t));
      end
    end else if (r.func == rbma_pkg::FUNC_CLEAR) begin
      body_mass = '0;
      for (int i = 0; i < 3; i++) body_com[i] = '0;
      for (int i = 0; i < 6; i++) body_inertia[i] = '0;
    end
    o.total_mass     = body_mass;
    o.com_x          = body_com[0];
    o.com_y          = body_com[1];
    o.com_z          = body_com[2];
    o.ixx            = body_inertia[0];
    o.iyy            = body_inertia[1];
    o.izz            = body_inertia[2];
    o.ixy            = body_inertia[3];
    o.ixz            = body_inertia[4];
    o.iyz            = body_inertia[5];
    o.zero_mass_flag = (body_mass == 0);
    return o;
  endfunction

  function automatic void check_field(string fname, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", fname, e, a);
      fail_count++;
    end
  endfunction

  // Monitor: requests feed the model, results are checked in order.
  always @(posedge clk) begin
    rbma_pkg::out_t pred;
    rbma_pkg::out_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pred = predict_body(in_data);
        if (typed_has_q.pop_front()) result_q.push_back(typed_val_q.pop_front());
        else begin
          void'(typed_val_q.pop_front());
          result_q.push_back(pred);
        end
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("result with no request pending");
          fail_count++;
        end else begin
          e = result_q.pop_front();
          check_field("total_mass", 64'(e.total_mass), 64'(out_data.total_mass));
          check_field("com_x", 64'(e.com_x), 64'(out_data.com_x));
          check_field("com_y", 64'(e.com_y), 64'(out_data.com_y));
          check_field("com_z", 64'(e.com_z), 64'(out_data.com_z));
          check_field("ixx", 64'(e.ixx), 64'(out_data.ixx));
          check_field("iyy", 64'(e.iyy), 64'(out_data.iyy));
          check_field("izz", 64'(e.izz), 64'(out_data.izz));
          check_field("ixy", 64'(e.ixy), 64'(out_data.ixy));
          check_field("ixz", 64'(e.ixz), 64'(out_data.ixz));
          check_field("iyz", 64'(e.iyz), 64'(out_data.iyz));
          check_field("zero_mass_flag", 64'(e.zero_mass_flag),
                      64'(out_data.zero_mass_flag));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int  g;
    bit  held;
    held = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 300) begin
        held = 1;
        out_ready = 1'b0;
        repeat (3000) @(negedge clk);
      end
      g = pick_gap();
      if (g > 0) begin
        out_ready = 1'b0;
        repeat (g - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic logic [47:0] rand48();
    return {$urandom(), 16'($urandom())};
  endfunction

  function automatic rbma_pkg::in_t make_req(logic [1:0] f, logic [31:0] m,
                                   logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                   logic [47:0] ia, logic [47:0] ib, logic [47:0] coff,
                                   logic [31:0] c);
    rbma_pkg::in_t r;
    r.func = f;
    r.part_mass = m;
    r.part_com_x = cx;
    r.part_com_y = cy;
    r.part_com_z = cz;
    r.part_ixx = ia;
    r.part_iyy = ib;
    r.part_izz = ia;
    r.part_ixy = coff;
    r.part_ixz = coff;
    r.part_iyz = coff;
    r.scale_coeff = c;
    return r;
  endfunction

  function automatic rbma_pkg::in_t rand_req();
    rbma_pkg::in_t r;
    int  k;
    k = $urandom_range(0, 99);
    r.func = (k < 65) ? rbma_pkg::FUNC_ADD :
             (k < 88) ? rbma_pkg::FUNC_SCALE :
             (k < 95) ? rbma_pkg::FUNC_CLEAR : FUNC_UNUSED;
    r.part_mass = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0008_0000);
    if ($urandom_range(0, 3) == 0) begin
      r.part_com_x = $urandom();
      r.part_com_y = $urandom();
      r.part_com_z = $urandom();
    end else begin
      r.part_com_x = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      r.part_com_y = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      r.part_com_z = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    end
    if ($urandom_range(0, 3) == 0) begin
      r.part_ixx = rand48();
      r.part_iyy = rand48();
      r.part_izz = rand48();
      r.part_ixy = rand48();
      r.part_ixz = rand48();
      r.part_iyz = rand48();
    end else begin
      r.part_ixx = 48'($urandom_range(0, 32'h0100_0000));
      r.part_iyy = 48'($urandom_range(0, 32'h0100_0000));
      r.part_izz = 48'($urandom_range(0, 32'h0100_0000));
      r.part_ixy = 48'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      r.part_ixz = 48'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      r.part_iyz = 48'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    end
    r.scale_coeff = ($urandom_range(0, 3) == 0) ? $urandom() :
                    $urandom_range(32'h0000_C000, 32'h0001_4000);
    return r;
  endfunction

  task automatic send_req(rbma_pkg::in_t r, bit has_typed, rbma_pkg::out_t typed);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    typed_has_q.push_back(has_typed);
    typed_val_q.push_back(typed);
    in_data = r;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  rbma_pkg::in_t  dir_req [$];
  bit             dir_has [$];
  rbma_pkg::out_t dir_val [$];

  initial begin
    rbma_pkg::out_t zero_state;
    rbma_pkg::out_t none;
    int   wait_cycles;
    fail_count = 0;
    results_seen = 0;
    cycle_count = 0;
    body_mass = '0;
    for (int i = 0; i < 3; i++) body_com[i] = '0;
    for (int i = 0; i < 6; i++) body_inertia[i] = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    zero_state = '0;
    zero_state.zero_mass_flag = 1'b1;
    none = '0;

    // Directed table: typed results only where they are obvious.
    dir_req.push_back(make_req(FUNC_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1));
    dir_has.push_back(1); dir_val.push_back(zero_state);
    dir_req.push_back(make_req(rbma_pkg::FUNC_ADD, '0, 32'h8000_0000, 32'h7FFF_FFFF, '0,
                               '0, '0, '0, '0));
    dir_has.push_back(1); dir_val.push_back(zero_state);
    dir_req.push_back(make_req(rbma_pkg::FUNC_SCALE, '0, '0, '0, '0, '0, '0, '0, '1));
    dir_has.push_back(1); dir_val.push_back(zero_state);
    // Zero total mass: tensors just add, centre stays put.
    dir_req.push_back(make_req(rbma_pkg::FUNC_ADD, '0, 32'h7FFF_FFFF, '0, '0,
                               48'h0000_1000_0000, 48'h0000_2000_0000, 48'hFFFF_F000_0000,
                               '0));
    dir_has.push_back(0); dir_val.push_back(none);
    dir_req.push_back(make_req(rbma_pkg::FUNC_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1));
    dir_has.push_back(1); dir_val.push_back(zero_state);
    dir_req.push_back(make_req(rbma_pkg::FUNC_ADD, '1, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000,
                               48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                               '0));
    dir_has.push_back(0); dir_val.push_back(none);
    // Mass saturates; division still uses the exact sum.
    dir_req.push_back(make_req(rbma_pkg::FUNC_ADD, '1, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF,
                               48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                               '0));
    dir_has.push_back(0); dir_val.push_back(none);
    dir_req.push_back(make_req(rbma_pkg::FUNC_SCALE, '0, '0, '0, '0, '0, '0, '0, '1));
    dir_has.push_back(0); dir_val.push_back(none);
    dir_req.push_back(make_req(rbma_pkg::FUNC_SCALE, '0, '0, '0, '0, '0, '0, '0,
                               32'h0000_8000));
    dir_has.push_back(0); dir_val.push_back(none);
    dir_req.push_back(make_req(rbma_pkg::FUNC_ADD, 32'h0001_0000, 32'h0001_0000, '0,
                               32'hFFFF_0000,
                               48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
                               '0));
    dir_has.push_back(0); dir_val.push_back(none);
    dir_req.push_back(make_req(FUNC_UNUSED, '0, '0, '0, '0, '0, '0, '0, '0));
    dir_has.push_back(0); dir_val.push_back(none);
    dir_req.push_back(make_req(rbma_pkg::FUNC_SCALE, '0, '0, '0, '0, '0, '0, '0,
                               32'h0001_0000));
    dir_has.push_back(0); dir_val.push_back(none);
    dir_req.push_back(make_req(rbma_pkg::FUNC_SCALE, '0, '0, '0, '0, '0, '0, '0, '0));
    dir_has.push_back(0); dir_val.push_back(none);
    dir_req.push_back(make_req(rbma_pkg::FUNC_ADD, 32'h0002_0000, 32'h0003_0000,
                               32'hFFFE_0000, 32'h0000_8000,
                               48'h1_0000, 48'h2_0000, 48'hFFFF_FFFF_0000, '0));
    dir_has.push_back(0); dir_val.push_back(none);
    dir_req.push_back(make_req(rbma_pkg::FUNC_ADD, 32'h0001_8000, 32'hFFFD_0000,
                               32'h0004_0000, 32'hFFFF_8000,
                               48'h3_0000, 48'h1_0000, 48'h8000, '0));
    dir_has.push_back(0); dir_val.push_back(none);
    dir_req.push_back(make_req(rbma_pkg::FUNC_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0));
    dir_has.push_back(1); dir_val.push_back(zero_state);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < dir_req.size(); i++) send_req(dir_req[i], dir_has[i], dir_val[i]);
    for (int i = 0; i < N_RANDOM; i++) send_req(rand_req(), 0, none);
    in_valid = 1'b0;

    while (result_q.size() != 0 || typed_has_q.size() != 0) @(posedge clk);
    wait_cycles = 400;
    repeat (wait_cycles) @(posedge clk);

    if (fail_count == 0 && result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rbma_pkg.sv
rtl/rigid_body_mass_accumulator_top.sv
bench/tb_rigid_body_mass_accumulator_top.sv
